// File: hw/rtl/mgth_pkg.sv
// Shared types, constants and saturating helpers for the GTH stationary solver.
// Used by mgth_muldiv, mgth_ctrl, mgth_dp and markov_stationary_gth.
`default_nettype none

package mgth_pkg;

    localparam int MAX_STATES = 32;
    localparam int IDX_W      = $clog2(MAX_STATES);
    localparam int SIZE_W     = 6;
    localparam int ADDR_W     = $clog2(MAX_STATES * MAX_STATES);
    localparam int CNT_W      = 11;
    localparam int DATA_W     = 64;
    localparam int PROB_W     = 33;
    localparam int OUT_DATA_W = 40;

    localparam logic [CNT_W-1:0]         CNT_MAX = '1;
    localparam logic signed [DATA_W-1:0] FX_ONE  = 64'sh0000_0001_0000_0000;
    localparam logic signed [DATA_W-1:0] S64_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S64_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0]        U63_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    // result status codes
    typedef logic [1:0] status_t;
    localparam status_t STAT_OK    = 2'd0;
    localparam status_t STAT_COUNT = 2'd1;
    localparam status_t STAT_PIVOT = 2'd2;

    // datapath register operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACC_CLR,
        OP_ACC_MAG_MAT,
        OP_ACC_MAG_X,
        OP_ACC_ADD_RES,
        OP_PIV_SET,
        OP_LAT_A,
        OP_START_UPD,
        OP_START_SCL,
        OP_START_BS,
        OP_START_PROB
    } op_t;

    typedef enum logic {MW_UPD, MW_RES} mw_sel_t;
    typedef enum logic {XW_ONE, XW_ACC} xw_sel_t;

    // controller to datapath
    typedef struct packed {
        logic             load;
        logic             count_clr;
        op_t              op;
        logic             rd_mat;
        logic             wr_mat;
        mw_sel_t          mw_sel;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] xidx;
        logic             rd_x;
        logic             wr_x;
        xw_sel_t          xw_sel;
        logic             out_load;
        logic             out_last;
        status_t          out_status;
    } cmd_t;

    localparam cmd_t CMD_NONE = '{
        load: 1'b0, count_clr: 1'b0, op: OP_NONE, rd_mat: 1'b0, wr_mat: 1'b0,
        mw_sel: MW_UPD, row: '0, col: '0, xidx: '0, rd_x: 1'b0, wr_x: 1'b0,
        xw_sel: XW_ONE, out_load: 1'b0, out_last: 1'b0, out_status: STAT_OK
    };

    // datapath to controller
    typedef struct packed {
        logic [SIZE_W-1:0] n;
        logic              count_hit;
        logic              acc_zero;
        logic              div_busy;
        logic              div_done;
        logic              out_free;
    } stat_t;

    // magnitude of a signed word as unsigned
    function automatic logic [DATA_W-1:0] mag64(input logic signed [DATA_W-1:0] v);
        logic [DATA_W-1:0] u;
        u = v;
        return v[DATA_W-1] ? (~u + 1'b1) : u;
    endfunction

    // signed add clamped to the int64 range
    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? S64_MIN : S64_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

    // unsigned add clamped to 2^63-1
    function automatic logic [DATA_W-1:0] usat_add(
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b
    );
        logic [DATA_W-1:0] ac;
        logic [DATA_W:0]   s;
        ac = (a > U63_MAX) ? U63_MAX : a;
        s  = {1'b0, ac} + {1'b0, b};
        return (s > {1'b0, U63_MAX}) ? U63_MAX : s[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mgth_muldiv.sv
// Sequential (a*b)/d unit: 32x32 partial products, then restoring division,
// or a plain shift when d is 1.0. Depends on mgth_pkg.
// Result truncates toward zero and saturates to int64.
`default_nettype none

module mgth_muldiv (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                start,
    input  wire logic signed [mgth_pkg::DATA_W-1:0]  mul_a,
    input  wire logic signed [mgth_pkg::DATA_W-1:0]  mul_b,
    input  wire logic        [mgth_pkg::DATA_W-1:0]  div_d,
    output logic                                     busy,
    output logic                                     done,
    output logic signed      [mgth_pkg::DATA_W-1:0]  result
);
    import mgth_pkg::*;

    localparam int HALF_W = DATA_W / 2;

    typedef enum logic [2:0] {D_IDLE, D_MUL, D_CHK, D_DIV, D_FIN} dstate_t;

    dstate_t                  state_reg;
    logic [5:0]               step_reg;
    logic                     done_reg;
    logic [DATA_W-1:0]        ua_reg;
    logic [DATA_W-1:0]        ub_reg;
    logic [DATA_W-1:0]        d_reg;
    logic                     neg_reg;
    logic [DATA_W-1:0]        pp_reg;
    logic [DATA_W-1:0]        hi_reg;
    logic [DATA_W-1:0]        lo_reg;
    logic [DATA_W-1:0]        q_reg;
    logic signed [DATA_W-1:0] result_reg;

    logic [HALF_W-1:0]   pa;
    logic [HALF_W-1:0]   pb;
    logic [DATA_W-1:0]   pp_full;
    logic [2*DATA_W-1:0] pp_shift;
    logic [2*DATA_W-1:0] prod_sum;
    logic [DATA_W:0]     rr;
    logic [DATA_W:0]     rr_diff;
    logic                rr_ge;

    // pick the partial product halves and its weight
    always_comb begin
        pa = step_reg[2] ? ua_reg[DATA_W-1:HALF_W] : ua_reg[HALF_W-1:0];
        pb = step_reg[1] ? ub_reg[DATA_W-1:HALF_W] : ub_reg[HALF_W-1:0];
        pp_full = {{HALF_W{1'b0}}, pa} * {{HALF_W{1'b0}}, pb};
        case (step_reg[2:1])
            2'd0:    pp_shift = {{DATA_W{1'b0}}, pp_reg};
            2'd3:    pp_shift = {pp_reg, {DATA_W{1'b0}}};
            default: pp_shift = {{HALF_W{1'b0}}, pp_reg, {HALF_W{1'b0}}};
        endcase
        prod_sum = {hi_reg, lo_reg} + pp_shift;
        rr       = {hi_reg, lo_reg[DATA_W-1]};
        rr_diff  = rr - {1'b0, d_reg};
        rr_ge    = (rr >= {1'b0, d_reg});
    end

    // sequence multiply, range check, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE: begin
                    if (start) begin
                        ua_reg    <= mag64(mul_a);
                        ub_reg    <= mag64(mul_b);
                        d_reg     <= div_d;
                        neg_reg   <= mul_a[DATA_W-1] != mul_b[DATA_W-1];
                        hi_reg    <= '0;
                        lo_reg    <= '0;
                        step_reg  <= '0;
                        state_reg <= D_MUL;
                    end
                end
                D_MUL: begin
                    if (!step_reg[0]) begin
                        pp_reg <= pp_full;
                    end else begin
                        {hi_reg, lo_reg} <= prod_sum;
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 6'd7) begin
                        state_reg <= D_CHK;
                    end
                end
                D_CHK: begin
                    step_reg <= '0;
                    q_reg    <= '0;
                    if (hi_reg >= d_reg) begin
                        result_reg <= neg_reg ? S64_MIN : S64_MAX;
                        done_reg   <= 1'b1;
                        state_reg  <= D_IDLE;
                    end else if (d_reg == FX_ONE) begin
                        // divide by 1.0: take the middle word of the product
                        q_reg     <= {hi_reg[HALF_W-1:0], lo_reg[DATA_W-1:HALF_W]};
                        state_reg <= D_FIN;
                    end else begin
                        state_reg <= D_DIV;
                    end
                end
                D_DIV: begin
                    hi_reg   <= rr_ge ? rr_diff[DATA_W-1:0] : rr[DATA_W-1:0];
                    lo_reg   <= {lo_reg[DATA_W-2:0], 1'b0};
                    q_reg    <= {q_reg[DATA_W-2:0], rr_ge};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == '1) begin
                        state_reg <= D_FIN;
                    end
                end
                D_FIN: begin
                    if (neg_reg) begin
                        result_reg <= q_reg[DATA_W-1] ? S64_MIN : -$signed(q_reg);
                    end else begin
                        result_reg <= q_reg[DATA_W-1] ? S64_MAX : $signed(q_reg);
                    end
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign busy   = state_reg != D_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// File: hw/rtl/mgth_dp.sv
// Datapath: size register, matrix and solution memories, accumulators,
// the mul/div unit and the result register. Depends on mgth_pkg, mgth_muldiv.
`default_nettype none

module mgth_dp (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    input  wire logic [mgth_pkg::SIZE_W-1:0]         cfg_data,
    input  wire logic [mgth_pkg::DATA_W-1:0]         s_tdata,
    input  wire mgth_pkg::cmd_t                      cmd,
    output mgth_pkg::stat_t                          stat,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [mgth_pkg::OUT_DATA_W-1:0]          m_tdata,
    output logic [1:0]                               m_tuser,
    output logic                                     m_tlast
);
    import mgth_pkg::*;

    localparam int DEPTH = MAX_STATES * MAX_STATES;

    logic [SIZE_W-1:0]        size_reg;
    logic [CNT_W-1:0]         count_reg;
    logic signed [DATA_W-1:0] mat_mem [DEPTH];
    logic signed [DATA_W-1:0] x_mem [MAX_STATES];
    logic signed [DATA_W-1:0] mat_rd_reg;
    logic signed [DATA_W-1:0] x_rd_reg;
    logic signed [DATA_W-1:0] opa_reg;
    logic [DATA_W-1:0]        acc_reg;
    logic [DATA_W-1:0]        piv_reg;

    logic                     out_valid_reg;
    logic [OUT_DATA_W-1:0]    out_data_reg;
    status_t                  out_status_reg;
    logic                     out_last_reg;

    logic [SIZE_W-1:0]        n_cur;
    logic [CNT_W-1:0]         total;
    logic [CNT_W-1:0]         count_inc;
    logic [IDX_W+SIZE_W-1:0]  rc_prod;
    logic [ADDR_W-1:0]        rc_addr;
    logic                     mw_en;
    logic [ADDR_W-1:0]        mw_addr;
    logic signed [DATA_W-1:0] mw_data;
    logic signed [DATA_W-1:0] xw_data;

    logic                     div_start;
    logic signed [DATA_W-1:0] div_a;
    logic signed [DATA_W-1:0] div_b;
    logic [DATA_W-1:0]        div_d;
    logic                     div_busy;
    logic                     div_done;
    logic signed [DATA_W-1:0] div_res;
    logic [PROB_W-1:0]        prob;

    // clamp the state count and derive the load target
    always_comb begin
        if (size_reg < SIZE_W'(2)) begin
            n_cur = SIZE_W'(2);
        end else if (size_reg > SIZE_W'(MAX_STATES)) begin
            n_cur = SIZE_W'(MAX_STATES);
        end else begin
            n_cur = size_reg;
        end
        total     = CNT_W'(n_cur) * CNT_W'(n_cur);
        count_inc = (count_reg == CNT_MAX) ? count_reg : count_reg + 1'b1;
        rc_prod   = cmd.row * n_cur;
        rc_addr   = ADDR_W'(rc_prod + (IDX_W + SIZE_W)'(cmd.col));
    end

    // size register and load counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg  <= SIZE_W'(MAX_STATES);
            count_reg <= '0;
        end else begin
            if (cfg_valid) begin
                size_reg <= cfg_data;
            end
            if (cmd.load) begin
                count_reg <= cmd.count_clr ? '0 : count_inc;
            end
        end
    end

    // matrix write port: load beats or solve updates
    always_comb begin
        mw_en   = (cmd.load && (count_reg < total)) || cmd.wr_mat;
        mw_addr = cmd.load ? count_reg[ADDR_W-1:0] : rc_addr;
        if (cmd.load) begin
            mw_data = s_tdata;
        end else if (cmd.mw_sel == MW_UPD) begin
            mw_data = sat_add(mat_rd_reg, div_res);
        end else begin
            mw_data = div_res;
        end
        xw_data = (cmd.xw_sel == XW_ONE) ? FX_ONE : $signed(acc_reg);
    end

    // matrix store
    always_ff @(posedge aclk) begin
        if (mw_en) begin
            mat_mem[mw_addr] <= mw_data;
        end
        if (cmd.rd_mat) begin
            mat_rd_reg <= mat_mem[rc_addr];
        end
    end

    // solution vector
    always_ff @(posedge aclk) begin
        if (cmd.wr_x) begin
            x_mem[cmd.xidx] <= xw_data;
        end
        if (cmd.rd_x) begin
            x_rd_reg <= x_mem[cmd.xidx];
        end
    end

    // accumulator, pivot and operand registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_ACC_CLR:     acc_reg <= '0;
            OP_ACC_MAG_MAT: acc_reg <= usat_add(acc_reg, mag64(mat_rd_reg));
            OP_ACC_MAG_X:   acc_reg <= usat_add(acc_reg, mag64(x_rd_reg));
            OP_ACC_ADD_RES: acc_reg <= sat_add($signed(acc_reg), div_res);
            OP_PIV_SET:     piv_reg <= acc_reg;
            OP_LAT_A:       opa_reg <= mat_rd_reg;
            default:        ;
        endcase
    end

    // operand select for the mul/div unit
    always_comb begin
        div_start = 1'b0;
        div_a     = mat_rd_reg;
        div_b     = FX_ONE;
        div_d     = piv_reg;
        case (cmd.op)
            OP_START_UPD: begin
                div_start = 1'b1;
                div_a     = opa_reg;
                div_b     = mat_rd_reg;
            end
            OP_START_SCL: begin
                div_start = 1'b1;
            end
            OP_START_BS: begin
                div_start = 1'b1;
                div_a     = x_rd_reg;
                div_b     = mat_rd_reg;
                div_d     = FX_ONE;
            end
            OP_START_PROB: begin
                div_start = 1'b1;
                div_a     = x_rd_reg;
            end
            default: ;
        endcase
    end

    mgth_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .mul_a   (div_a),
        .mul_b   (div_b),
        .div_d   (div_d),
        .busy    (div_busy),
        .done    (div_done),
        .result  (div_res)
    );

    // probability: zero for a fault status or non-positive x, capped at 1.0
    always_comb begin
        if (cmd.out_status != STAT_OK || x_rd_reg[DATA_W-1] || x_rd_reg == '0) begin
            prob = '0;
        end else if (div_res > FX_ONE) begin
            prob = PROB_W'(FX_ONE);
        end else begin
            prob = div_res[PROB_W-1:0];
        end
    end

    // result register: load when free, drop on downstream accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg   <= OUT_DATA_W'({prob, cmd.xidx});
            out_status_reg <= cmd.out_status;
            out_last_reg   <= cmd.out_last;
        end
    end

    always_comb begin
        stat.n         = n_cur;
        stat.count_hit = count_inc == total;
        stat.acc_zero  = acc_reg == '0;
        stat.div_busy  = div_busy;
        stat.div_done  = div_done;
        stat.out_free  = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// File: hw/rtl/mgth_ctrl.sv
// Controller: load handshake and the elimination, back-substitution and
// normalize sequence over the datapath. Depends on mgth_pkg.
`default_nettype none

module mgth_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic            s_tlast,
    input  wire mgth_pkg::stat_t stat,
    output mgth_pkg::cmd_t       cmd
);
    import mgth_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_PV_RD, ST_PV_ACC, ST_PV_CHK,
        ST_UP_RDL, ST_UP_LATL, ST_UP_RDIL, ST_UP_START, ST_UP_WAIT, ST_UP_WR, ST_UP_NEXT,
        ST_SC_RD, ST_SC_START, ST_SC_WAIT, ST_SC_WR,
        ST_BS_INIT, ST_BS_RD, ST_BS_START, ST_BS_WAIT, ST_BS_ACC, ST_BS_WR,
        ST_SM_RD, ST_SM_ACC, ST_SM_CHK,
        ST_OT_RD, ST_OT_START, ST_OT_WAIT, ST_OT_EMIT,
        ST_ERR
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] l_reg, l_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    status_t          err_reg, err_next;

    logic [IDX_W-1:0] nm1;
    logic [IDX_W-1:0] lm1;
    logic             s_beat;

    assign nm1    = IDX_W'(stat.n - 1'b1);
    assign lm1    = l_reg - 1'b1;
    assign s_beat = s_tvalid && s_tready;

    // next state and datapath commands
    always_comb begin
        state_next = state_reg;
        l_next     = l_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        err_next   = err_reg;
        cmd        = CMD_NONE;
        s_tready   = (state_reg == ST_IDLE) && stat.out_free;
        case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    cmd.load = 1'b1;
                    if (s_tlast) begin
                        cmd.count_clr = 1'b1;
                        if (stat.count_hit) begin
                            l_next     = nm1;
                            j_next     = '0;
                            cmd.op     = OP_ACC_CLR;
                            state_next = ST_PV_RD;
                        end else begin
                            err_next   = STAT_COUNT;
                            state_next = ST_ERR;
                        end
                    end
                end
            end
            // pivot sum over row l left of the diagonal
            ST_PV_RD: begin
                cmd.rd_mat = 1'b1;
                cmd.row    = l_reg;
                cmd.col    = j_reg;
                state_next = ST_PV_ACC;
            end
            ST_PV_ACC: begin
                cmd.op = OP_ACC_MAG_MAT;
                if (j_reg == lm1) begin
                    state_next = ST_PV_CHK;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_PV_RD;
                end
            end
            ST_PV_CHK: begin
                if (stat.acc_zero) begin
                    err_next   = STAT_PIVOT;
                    state_next = ST_ERR;
                end else begin
                    cmd.op     = OP_PIV_SET;
                    j_next     = '0;
                    state_next = ST_UP_RDL;
                end
            end
            // rank-one update of the leading block
            ST_UP_RDL: begin
                cmd.rd_mat = 1'b1;
                cmd.row    = l_reg;
                cmd.col    = j_reg;
                state_next = ST_UP_LATL;
            end
            ST_UP_LATL: begin
                cmd.op     = OP_LAT_A;
                i_next     = '0;
                state_next = ST_UP_RDIL;
            end
            ST_UP_RDIL: begin
                if (i_reg == j_reg) begin
                    state_next = ST_UP_NEXT;
                end else begin
                    cmd.rd_mat = 1'b1;
                    cmd.row    = i_reg;
                    cmd.col    = l_reg;
                    state_next = ST_UP_START;
                end
            end
            ST_UP_START: begin
                cmd.op     = OP_START_UPD;
                cmd.rd_mat = 1'b1;
                cmd.row    = i_reg;
                cmd.col    = j_reg;
                state_next = ST_UP_WAIT;
            end
            ST_UP_WAIT: begin
                if (stat.div_done) begin
                    state_next = ST_UP_WR;
                end
            end
            ST_UP_WR: begin
                cmd.wr_mat = 1'b1;
                cmd.mw_sel = MW_UPD;
                cmd.row    = i_reg;
                cmd.col    = j_reg;
                state_next = ST_UP_NEXT;
            end
            ST_UP_NEXT: begin
                if (i_reg == lm1) begin
                    i_next = '0;
                    if (j_reg == lm1) begin
                        state_next = ST_SC_RD;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_UP_RDL;
                    end
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_UP_RDIL;
                end
            end
            // scale column l by the pivot sum
            ST_SC_RD: begin
                cmd.rd_mat = 1'b1;
                cmd.row    = i_reg;
                cmd.col    = l_reg;
                state_next = ST_SC_START;
            end
            ST_SC_START: begin
                cmd.op     = OP_START_SCL;
                state_next = ST_SC_WAIT;
            end
            ST_SC_WAIT: begin
                if (stat.div_done) begin
                    state_next = ST_SC_WR;
                end
            end
            ST_SC_WR: begin
                cmd.wr_mat = 1'b1;
                cmd.mw_sel = MW_RES;
                cmd.row    = i_reg;
                cmd.col    = l_reg;
                if (i_reg == lm1) begin
                    if (l_reg == IDX_W'(1)) begin
                        state_next = ST_BS_INIT;
                    end else begin
                        l_next     = lm1;
                        j_next     = '0;
                        cmd.op     = OP_ACC_CLR;
                        state_next = ST_PV_RD;
                    end
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_SC_RD;
                end
            end
            // back-substitution from x0 = 1.0
            ST_BS_INIT: begin
                cmd.wr_x   = 1'b1;
                cmd.xw_sel = XW_ONE;
                cmd.xidx   = '0;
                cmd.op     = OP_ACC_CLR;
                l_next     = IDX_W'(1);
                i_next     = '0;
                state_next = ST_BS_RD;
            end
            ST_BS_RD: begin
                cmd.rd_x   = 1'b1;
                cmd.xidx   = i_reg;
                cmd.rd_mat = 1'b1;
                cmd.row    = i_reg;
                cmd.col    = l_reg;
                state_next = ST_BS_START;
            end
            ST_BS_START: begin
                cmd.op     = OP_START_BS;
                state_next = ST_BS_WAIT;
            end
            ST_BS_WAIT: begin
                if (stat.div_done) begin
                    state_next = ST_BS_ACC;
                end
            end
            ST_BS_ACC: begin
                cmd.op = OP_ACC_ADD_RES;
                if (i_reg == lm1) begin
                    state_next = ST_BS_WR;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_BS_RD;
                end
            end
            ST_BS_WR: begin
                cmd.wr_x   = 1'b1;
                cmd.xw_sel = XW_ACC;
                cmd.xidx   = l_reg;
                cmd.op     = OP_ACC_CLR;
                i_next     = '0;
                if (l_reg == nm1) begin
                    state_next = ST_SM_RD;
                end else begin
                    l_next     = l_reg + 1'b1;
                    state_next = ST_BS_RD;
                end
            end
            // absolute sum of the solution
            ST_SM_RD: begin
                cmd.rd_x   = 1'b1;
                cmd.xidx   = i_reg;
                state_next = ST_SM_ACC;
            end
            ST_SM_ACC: begin
                cmd.op = OP_ACC_MAG_X;
                if (i_reg == nm1) begin
                    state_next = ST_SM_CHK;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_SM_RD;
                end
            end
            ST_SM_CHK: begin
                if (stat.acc_zero) begin
                    err_next   = STAT_PIVOT;
                    state_next = ST_ERR;
                end else begin
                    cmd.op     = OP_PIV_SET;
                    i_next     = '0;
                    state_next = ST_OT_RD;
                end
            end
            // normalize and emit one beat per state
            ST_OT_RD: begin
                cmd.rd_x   = 1'b1;
                cmd.xidx   = i_reg;
                state_next = ST_OT_START;
            end
            ST_OT_START: begin
                cmd.op     = OP_START_PROB;
                state_next = ST_OT_WAIT;
            end
            ST_OT_WAIT: begin
                if (stat.div_done) begin
                    state_next = ST_OT_EMIT;
                end
            end
            ST_OT_EMIT: begin
                cmd.xidx       = i_reg;
                cmd.out_status = STAT_OK;
                cmd.out_last   = i_reg == nm1;
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    if (i_reg == nm1) begin
                        state_next = ST_IDLE;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_OT_RD;
                    end
                end
            end
            ST_ERR: begin
                cmd.xidx       = '0;
                cmd.out_status = err_reg;
                cmd.out_last   = 1'b1;
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and loop counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            l_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            err_reg   <= STAT_OK;
        end else begin
            state_reg <= state_next;
            l_reg     <= l_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            err_reg   <= err_next;
        end
    end

    // a run closes the input until its results are out
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && s_tlast) |=> !s_tready)
        else $error("input still open after last beat");

    // the mul/div unit is started only when idle
    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_START_UPD || cmd.op == OP_START_SCL ||
         cmd.op == OP_START_BS || cmd.op == OP_START_PROB) |-> !stat.div_busy)
        else $error("mul/div started while busy");

    // never overwrite a pending result
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("result register overrun");

    // loading never shares the matrix port with the solve
    a_port_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !(cmd.wr_mat || cmd.rd_mat))
        else $error("matrix port conflict");

endmodule

`default_nettype wire

// File: hw/rtl/markov_stationary_gth.sv
// Top level of the GTH stationary distribution solver.
// Depends on mgth_pkg, mgth_ctrl, mgth_dp (which holds mgth_muldiv).
//
//   channel | direction | handshake           | payload
//   s_      | in        | s_tvalid / s_tready | s_tdata rate_entry, s_tlast entry_last
//   m_      | out       | m_tvalid / m_tready | m_tdata index+probability, m_tuser status
//   cfg_    | in        | cfg_valid/cfg_ready | cfg_data matrix_size, always ready
//
// The beat carrying tlast starts the solve; its time is set by the one shared
// mul/div unit, which for (a*b)/d steps through start, multiply, range check,
// divide and finish, and skips the divide when d is 1.0. Elimination takes
// about n^3/3 updates and n^2/2 column scalings, back-substitution n^2/2
// products by 1.0 and normalization n divides, each with reads and writes
// around it.
// Reset is synchronous on aresetn; the matrix and solution memories are not
// cleared. Input is closed during a solve and while a result is pending.
`default_nettype none

module markov_stationary_gth (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mgth_pkg::SIZE_W-1:0]       cfg_data,   // matrix_size
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [mgth_pkg::DATA_W-1:0]       s_tdata,    // rate_entry[63:0]
    input  wire logic                              s_tlast,    // entry_last
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [mgth_pkg::OUT_DATA_W-1:0]        m_tdata,    // state_index[4:0], probability[37:5]
    output logic [1:0]                             m_tuser,    // status[1:0]
    output logic                                   m_tlast     // result_last
);
    import mgth_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    mgth_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .stat     (stat),
        .cmd      (cmd)
    );

    mgth_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// File: sim/tb_markov_stationary_gth.sv
// Testbench for markov_stationary_gth: loads generator matrices, predicts the GTH
// stationary probabilities in fixed point and checks every result beat.
// Depends on mgth_pkg and the markov_stationary_gth RTL.
`timescale 1ns / 100ps

module tb_markov_stationary_gth;
    import mgth_pkg::*;

    localparam longint ONE_Q32 = 64'sh0000_0001_0000_0000;
    localparam longint INT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint INT_MIN = 64'sh8000_0000_0000_0000;
    localparam int     COUNT_CAP = 2047;
    localparam int     CYCLE_LIMIT = 6_000_000;
    localparam int     HOLD_CYCLES = 20_000;

    typedef struct {
        logic [DATA_W-1:0] rate;
        logic              last;
    } entry_t;

    typedef struct {
        logic [IDX_W-1:0]  state;
        logic [PROB_W-1:0] prob;
        status_t           status;
        logic              last;
    } prob_beat_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [SIZE_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [DATA_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;
    logic m_tlast;

    markov_stationary_gth i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    entry_t     pending_entries[$];
    prob_beat_t expected_probs[$];

    // predictor state
    longint     gen_matrix[MAX_STATES*MAX_STATES];
    longint     stat_vec[MAX_STATES];
    int         load_count = 0;
    int         size_reg = 32;

    int  fail_count = 0;
    int  entries_sent = 0;
    int  loads_sent = 0;
    int  beats_checked = 0;
    int  error_beats = 0;
    int  hold_left = 0;
    int  hold_asked = 0;
    int  hold_taken = 0;
    int  offered = 0;
    int  in_beats = 0;
    bit  calm = 1'b0;
    longint cycles = 0;

    function automatic logic [63:0] magnitude(longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function automatic longint clamp_add(longint a, longint b);
        if (b > 0 && a > INT_MAX - b) return INT_MAX;
        if (b < 0 && a < INT_MIN - b) return INT_MIN;
        return a + b;
    endfunction

    function automatic logic [63:0] mag_add(logic [63:0] a, logic [63:0] b);
        logic [63:0] cap;
        cap = 64'(INT_MAX);
        if (a > cap) a = cap;
        if (b > cap - a) return cap;
        return a + b;
    endfunction

    // (a*b)/d on the full 128-bit product, truncated, saturated
    function automatic longint scaled_product(longint a, longint b, longint d);
        bit           neg;
        logic [127:0] prod;
        logic [127:0] quo;
        logic [63:0]  ud;
        neg  = (a < 0) != (b < 0);
        ud   = 64'(d);
        prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        if (prod[127:64] >= ud) return neg ? INT_MIN : INT_MAX;
        quo = prod / {64'd0, ud};
        if (neg) begin
            if (quo[63]) return INT_MIN;
            return -longint'(quo[63:0]);
        end
        if (quo[63]) return INT_MAX;
        return longint'(quo[63:0]);
    endfunction

    function automatic void push_fault(status_t code);
        prob_beat_t b;
        b.state = '0; b.prob = '0; b.status = code; b.last = 1'b1;
        expected_probs.push_back(b);
    endfunction

    // GTH elimination, back-substitution and normalization
    function automatic void gth_solve(int n);
        logic [63:0] t;
        logic [63:0] s;
        longint acc;
        longint q;
        prob_beat_t b;
        for (int l = n - 1; l >= 1; l--) begin
            t = 0;
            for (int j = 0; j < l; j++) t = mag_add(t, magnitude(gen_matrix[l*n+j]));
            if (t == 0) begin
                push_fault(STAT_PIVOT);
                return;
            end
            for (int j = 0; j < l; j++)
                for (int i = 0; i < l; i++)
                    if (i != j)
                        gen_matrix[i*n+j] = clamp_add(gen_matrix[i*n+j],
                            scaled_product(gen_matrix[l*n+j], gen_matrix[i*n+l], longint'(t)));
            for (int i = 0; i < l; i++) begin
                gen_matrix[i*n+l] = scaled_product(gen_matrix[i*n+l], ONE_Q32, longint'(t));
                gen_matrix[l*n+i] = 0;
            end
            gen_matrix[l*n+l] = -ONE_Q32;
        end
        stat_vec[0] = ONE_Q32;
        for (int l = 1; l < n; l++) begin
            acc = 0;
            for (int i = 0; i < l; i++)
                acc = clamp_add(acc, scaled_product(stat_vec[i], gen_matrix[i*n+l], ONE_Q32));
            stat_vec[l] = acc;
        end
        s = 0;
        for (int i = 0; i < n; i++) s = mag_add(s, magnitude(stat_vec[i]));
        if (s == 0) begin
            push_fault(STAT_PIVOT);
            return;
        end
        for (int i = 0; i < n; i++) begin
            b.state = i[IDX_W-1:0];
            if (stat_vec[i] <= 0) b.prob = '0;
            else begin
                q = scaled_product(stat_vec[i], ONE_Q32, longint'(s));
                b.prob = q > ONE_Q32 ? PROB_W'(ONE_Q32) : PROB_W'(q);
            end
            b.status = STAT_OK;
            b.last = (i == n - 1);
            expected_probs.push_back(b);
        end
    endfunction

    function automatic void take_entry(logic [63:0] rate, logic last);
        int n;
        n = size_reg < 2 ? 2 : (size_reg > MAX_STATES ? MAX_STATES : size_reg);
        if (load_count < n * n) gen_matrix[load_count] = longint'(rate);
        if (load_count < COUNT_CAP) load_count++;
        if (!last) return;
        if (load_count != n * n) begin
            load_count = 0;
            push_fault(STAT_COUNT);
        end else begin
            load_count = 0;
            gth_solve(n);
        end
    endfunction

    // sender: hold a beat until it is taken, then offer the next, idling at random
    always @(negedge aclk) begin
        if (in_beats == offered) begin
            if (aresetn && pending_entries.size() > 0
                    && (calm || $urandom_range(0, 99) >= 33)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_entries[0].rate;
                s_tlast  <= pending_entries[0].last;
                offered++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // predict on every accepted entry beat
    always @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            void'(pending_entries.pop_front());
            take_entry(s_tdata, s_tlast);
            in_beats++;
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(negedge aclk) begin
        if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= aresetn && (calm || $urandom_range(0, 99) >= 33);
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        prob_beat_t e;
        if (m_tvalid && m_tready) begin
            if (expected_probs.size() == 0) begin
                $error("unexpected result beat tdata=%h tuser=%0d", m_tdata, m_tuser);
                fail_count++;
            end else begin
                e = expected_probs.pop_front();
                beats_checked++;
                if (e.status != STAT_OK) error_beats++;
                if (m_tdata[IDX_W-1:0] !== e.state) begin
                    $error("state_index exp %0d got %0d", e.state, m_tdata[IDX_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[IDX_W+PROB_W-1:IDX_W] !== e.prob) begin
                    $error("probability exp %0d got %0d", e.prob,
                           m_tdata[IDX_W+PROB_W-1:IDX_W]);
                    fail_count++;
                end
                if (m_tuser !== e.status) begin
                    $error("status exp %0d got %0d", e.status, m_tuser);
                    fail_count++;
                end
                if (m_tlast !== e.last) begin
                    $error("result_last exp %0d got %0d", e.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_entries.size() > 0 || s_tvalid || expected_probs.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_size(int value);
        wait_drained();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value[SIZE_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        size_reg = cfg_data;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_entry(logic [63:0] rate, logic last);
        entry_t e;
        e.rate = rate; e.last = last;
        pending_entries.push_back(e);
        entries_sent++;
        if (last) loads_sent++;
    endtask

    function automatic logic [63:0] any_word();
        return {$urandom(), $urandom()};
    endfunction

    // proper generator: nonnegative rates off the diagonal, rows summing to zero
    task automatic queue_generator(int n, bit dead_pivot);
        longint row[MAX_STATES];
        longint sum;
        for (int i = 0; i < n; i++) begin
            sum = 0;
            for (int j = 0; j < n; j++) begin
                if (i == j) row[j] = 0;
                else if (dead_pivot && i == n - 1) row[j] = 0;
                else if ($urandom_range(0, 7) == 0) row[j] = 0;
                else row[j] = {32'($urandom_range(0, 5)), $urandom()};
                sum += row[j];
            end
            row[i] = -sum;
            for (int j = 0; j < n; j++) queue_entry(row[j], i == n - 1 && j == n - 1);
        end
    endtask

    task automatic queue_noise(int count);
        for (int k = 0; k < count; k++) queue_entry(any_word(), k == count - 1);
    endtask

    initial begin
        int n;
        int kind;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: smallest sizes, clamped sizes, extremes, each fault
        write_size(0);
        queue_generator(2, 0);
        queue_entry(64'h8000_0000_0000_0000, 1'b0);
        queue_entry(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        queue_entry(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        queue_entry(64'h8000_0000_0000_0000, 1'b1);
        queue_generator(2, 1);
        queue_entry(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        write_size(1);
        queue_entry(64'd0, 1'b0);
        queue_entry(64'h0000_0001_0000_0000, 1'b0);
        queue_entry(64'd1, 1'b0);
        queue_entry(64'd0, 1'b0);
        queue_entry(64'd5, 1'b1);
        write_size(3);
        queue_generator(3, 0);

        // oversize setting clamps to the largest matrix: a short load misses the count
        write_size(40);
        queue_noise(5);
        wait_drained();

        // random loads, mostly proper generators of small size
        while (entries_sent < 400) begin
            n = $urandom_range(2, 6);
            write_size(n);
            if (loads_sent == 18) hold_asked++;
            calm = loads_sent >= 22 && loads_sent < 28;
            kind = $urandom_range(0, 9);
            if (kind < 7) queue_generator(n, 0);
            else if (kind == 7) queue_generator(n, 1);
            else if (kind == 8) queue_noise(n * n);
            else queue_noise($urandom_range(0, 1) ? n * n - 1 : n * n + 1);
        end

        wait_drained();
        $display("%0d matrix loads, %0d result beats checked, %0d fault results",
                 loads_sent, beats_checked, error_beats);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
